[hw/rtl/assert_macros.svh]
// Concurrent assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge, with the check off while reset is asserted.
`define MD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: lbl");

// Check that cond never holds on a rising clock edge outside reset.
`define MD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `MD_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define MD_ASSERT(lbl, clk, rst_n, prop)
`define MD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[hw/rtl/md_adl_pkg.sv]
// Types and constants for the chained Adler-32 hash.
`default_nettype none

package md_adl_pkg;

  localparam int unsigned LowW  = 11;
  localparam int unsigned HighW = 14;
  localparam int unsigned FillW = 3;

  localparam logic [31:0]      DefaultChain = 32'hABBA_1234;
  localparam logic [LowW-1:0]  LowInit      = LowW'(1);
  // Eight bytes of 0xff starting from 1 bound the sums well below 65521,
  // so the modulo reduction never fires.
  localparam logic [LowW-1:0]  LowMax       = LowW'(2041);
  localparam logic [HighW-1:0] HighMax      = HighW'(16328);

  typedef struct packed {
    logic [31:0]      chain;
    logic [LowW-1:0]  low_sum;
    logic [HighW-1:0] high_sum;
    logic [FillW-1:0] block_fill;
  } md_state_t;

endpackage

`default_nettype wire

[hw/rtl/md_chained_adler32_hash.sv]
// Top level of the chained Adler-32 message hash.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | sink      | in_valid_i / in_stall_o | data_byte_i, byte_present_i, last_i
//   out     | source    | out_valid_o / out_stall_i | hash_o
//   cfg     | sink      | cfg_we_i               | cfg_data_i (initial_chain)
//
// One item per cycle while the input does not stall: an item is held in the input register,
// then one pass of the step logic updates the block sums and the chain.
// A last item's hash goes to the output register, or to the skid while main is stalled.
// A two-entry output (main register plus skid) keeps input flowing while a
// hash waits; input stalls only when the skid is full and an item waits in the input register.
// Reset loads initial_chain and chain with 0xabba1234 and opens an empty block.
`default_nettype none
`include "assert_macros.svh"

module md_chained_adler32_hash import md_adl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  // input register
  logic        in_valid_q;
  logic [7:0]  data_q;
  logic        present_q;
  logic        last_q;

  // hash state and configuration
  md_state_t   state_q, state_d, step_state;
  logic [31:0] initial_q;

  // output register and skid entry
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  logic [31:0] out_hash_q, out_hash_d;
  logic [31:0] skid_hash_q, skid_hash_d;

  logic        step_res_valid;
  logic [31:0] step_res_hash;
  logic        proc_go;
  logic        in_take;
  logic        res_v;
  logic        main_take;
  logic        block_fresh;

  // Process the held item whenever the skid entry has room for its hash.
  assign proc_go    = in_valid_q && !skid_valid_q;
  assign in_stall_o = in_valid_q && skid_valid_q;
  assign in_take    = in_valid_i && !in_stall_o;

  md_adl_step u_step (
    .state_i         (state_q),
    .initial_chain_i (initial_q),
    .data_byte_i     (data_q),
    .byte_present_i  (present_q),
    .last_i          (last_q),
    .state_o         (step_state),
    .result_valid_o  (step_res_valid),
    .result_hash_o   (step_res_hash)
  );

  assign res_v     = proc_go && step_res_valid;
  assign main_take = out_valid_q && !out_stall_i;

  always_comb begin
    state_d = proc_go ? step_state : state_q;
    // Retarget the running chain to a new start value.
    if (cfg_we_i) begin
      state_d.chain = state_d.chain ^ initial_q ^ cfg_data_i;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_hash_d   = out_hash_q;
    skid_valid_d = skid_valid_q;
    skid_hash_d  = skid_hash_q;
    if (!out_valid_q || main_take) begin
      // main register free: refill from skid first, then from the step
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_hash_d   = skid_hash_q;
        skid_valid_d = 1'b0;
      end else if (res_v) begin
        out_valid_d = 1'b1;
        out_hash_d  = step_res_hash;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_v) begin
      // main held by a stall: park the new hash
      skid_valid_d = 1'b1;
      skid_hash_d  = step_res_hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      initial_q            <= DefaultChain;
      state_q.chain        <= DefaultChain;
      state_q.low_sum      <= LowInit;
      state_q.high_sum     <= '0;
      state_q.block_fill   <= '0;
      out_valid_q          <= 1'b0;
      skid_valid_q         <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (proc_go) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        initial_q <= cfg_data_i;
      end
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q    <= data_byte_i;
      present_q <= byte_present_i;
      last_q    <= last_i;
    end
    out_hash_q  <= out_hash_d;
    skid_hash_q <= skid_hash_d;
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = out_hash_q;

  // block sums back at their opening values
  assign block_fresh = (state_q.block_fill == '0) && (state_q.low_sum == LowInit) &&
                       (state_q.high_sum == '0);

  `MD_ASSERT(a_skid_behind_main, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `MD_ASSERT(a_block_reopens, clk_i, rst_ni, (proc_go && last_q) |=> block_fresh)
  `MD_ASSERT_NEVER(a_sum_bound, clk_i, rst_ni, state_q.low_sum > LowMax || state_q.high_sum > HighMax)

endmodule

`default_nettype wire

[hw/rtl/md_adl_step.sv]
// Next-state and result logic for one message item.
`default_nettype none

module md_adl_step import md_adl_pkg::*; (
  input  md_state_t   state_i,
  input  logic [31:0] initial_chain_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output md_state_t   state_o,
  output logic        result_valid_o,
  output logic [31:0] result_hash_o
);

  logic [LowW-1:0]  low_add;
  logic [HighW-1:0] high_add;
  logic [HighW-1:0] high_pad;
  logic [FillW-1:0] fill_inc;
  logic [FillW-1:0] pad_cnt;
  logic             full;
  logic             pad;
  logic [31:0]      chain_x;

  always_comb begin
    low_add  = state_i.low_sum + (byte_present_i ? LowW'(data_byte_i) : LowW'(0));
    high_add = byte_present_i ? (state_i.high_sum + HighW'(low_add)) : state_i.high_sum;
    fill_inc = state_i.block_fill + FillW'(byte_present_i);
    // fill wraps to zero when the eighth byte lands
    full     = byte_present_i && (fill_inc == '0);
    pad      = last_i && !full && (fill_inc != '0);
    pad_cnt  = FillW'(~fill_inc + FillW'(1));
    high_pad = high_add + HighW'(HighW'(pad_cnt) * HighW'(low_add));

    chain_x = state_i.chain;
    if (full) begin
      chain_x = state_i.chain ^ {2'b00, high_add, 5'b00000, low_add};
    end else if (pad) begin
      chain_x = state_i.chain ^ {2'b00, high_pad, 5'b00000, low_add};
    end

    result_valid_o = last_i;
    result_hash_o  = chain_x;

    if (last_i || full) begin
      state_o.low_sum    = LowInit;
      state_o.high_sum   = '0;
      state_o.block_fill = '0;
    end else begin
      state_o.low_sum    = low_add;
      state_o.high_sum   = high_add;
      state_o.block_fill = fill_inc;
    end
    state_o.chain = last_i ? initial_chain_i : chain_x;
  end

endmodule

`default_nettype wire

[dv/md_chained_adler32_hash_tb.sv]
// Testbench for the chained Adler-32 message hash: random and directed messages, self-checking.
`timescale 1ns / 1ps

module md_chained_adler32_hash_tb;
  import md_adl_pkg::*;

  // Block geometry and the Adler-32 modulus.
  localparam int unsigned BlockBytes  = 8;
  localparam int unsigned AdlerMod    = 65521;
  // Idle cycles after the last hash before a register write or the end.
  localparam int unsigned DrainCycles = 10;
  // Receiver hold-off that backs the block up until its input stalls.
  localparam int unsigned HoldCycles  = 300;
  // Cycle budget for the whole run; far above the slowest legal run.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned IdlePct     = 34;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } msg_item_t;

  typedef enum int unsigned {
    PatRandom,
    PatOnes,
    PatZeros
  } byte_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] hash_o;
  logic        cfg_we_i;
  logic [31:0] cfg_data_i;

  // Items waiting for the driver, hashes waiting for the monitor.
  msg_item_t   pending_items[$];
  logic [31:0] hash_expected[$];

  // Predictor copy of the block state and its register.
  logic [31:0]      seed_chain;
  logic [31:0]      run_chain;
  logic [LowW-1:0]  run_low;
  logic [HighW-1:0] run_high;
  logic [FillW-1:0] run_fill;

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  md_chained_adler32_hash DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_o         (hash_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Open a fresh block: low sum 1, high sum 0, no bytes held.
  function automatic void adler_open_block();
    run_low  = LowInit;
    run_high = '0;
    run_fill = '0;
  endfunction

  // Fold the checksum of the current block into the chain, then reopen.
  function automatic void adler_close_block();
    logic [15:0] lo16;
    logic [15:0] hi16;
    lo16 = 16'(32'(run_low) % AdlerMod);
    hi16 = 16'(32'(run_high) % AdlerMod);
    run_chain = run_chain ^ {hi16, lo16};
    adler_open_block();
  endfunction

  // Register write: shift the chain by the change of the seed, so a message
  // in flight reads as if it had started from the new seed.
  function automatic void adler_chain_reseed(logic [31:0] value);
    run_chain  = run_chain ^ seed_chain ^ value;
    seed_chain = value;
  endfunction

  // Absorb one accepted item; a last item queues the hash it must produce.
  function automatic void adler_chain_absorb(msg_item_t it);
    if (it.present) begin
      run_low  = run_low + LowW'(it.data);
      run_high = run_high + HighW'(run_low);
      if (run_fill == FillW'(BlockBytes - 1)) begin
        adler_close_block();
      end else begin
        run_fill = run_fill + 1'b1;
      end
    end
    if (it.last) begin
      // Zero pad bytes leave the low sum alone and add it once each to the high sum.
      if (run_fill != '0) begin
        run_high = run_high + HighW'((BlockBytes - 32'(run_fill)) * 32'(run_low));
        adler_close_block();
      end
      hash_expected = {hash_expected, run_chain};
      run_chain = seed_chain;
      adler_open_block();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed pending items, hold the payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    msg_item_t nxt;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      data_byte_i    <= '0;
      byte_present_i <= 1'b0;
      last_i         <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        adler_chain_absorb('{data: data_byte_i, present: byte_present_i, last: last_i});
      end
      // Advance only when the current item went through or nothing is offered.
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i     <= 1'b1;
          data_byte_i    <= nxt.data;
          byte_present_i <= nxt.present;
          last_i         <= nxt.last;
        end else begin
          // Scramble the idle payload so it is seen to be ignored.
          in_valid_i     <= 1'b0;
          data_byte_i    <= 8'($urandom());
          byte_present_i <= 1'($urandom());
          last_i         <= 1'($urandom());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted hash against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold_left;
    bit          hold_done;
    logic [31:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (hash_expected.size() == 0) begin
          $display("%0t: unexpected hash: expected none, actual %08h", $time, hash_o);
          mismatch_count++;
        end else begin
          want = hash_expected.pop_front();
          if (hash_o !== want) begin
            $display("%0t: hash mismatch: expected %08h, actual %08h", $time, want, hash_o);
            mismatch_count++;
          end
        end
      end
      // Start the long hold-off once, on request; count it down here.
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue one message of nbytes bytes. The message ends either on its final
  // byte or on a separate empty end marker; an empty message always uses one.
  task automatic queue_message(input int unsigned nbytes, input bit empty_end,
                               input byte_pattern_e pattern);
    msg_item_t it;
    for (int unsigned i = 0; i < nbytes; i++) begin
      // Sprinkle idle items into random messages only.
      if (pattern == PatRandom && $urandom_range(0, 99) < 15) begin
        it.data    = 8'($urandom());
        it.present = 1'b0;
        it.last    = 1'b0;
        pending_items = {pending_items, it};
      end
      case (pattern)
        PatOnes:  it.data = 8'hFF;
        PatZeros: it.data = 8'h00;
        default:  it.data = 8'($urandom());
      endcase
      it.present = 1'b1;
      it.last    = (i == nbytes - 1) && !empty_end;
      pending_items = {pending_items, it};
    end
    if (empty_end || nbytes == 0) begin
      it.data    = 8'($urandom());
      it.present = 1'b0;
      it.last    = 1'b1;
      pending_items = {pending_items, it};
    end
  endtask

  // Extremes and each corner of the padding and end-marker rules.
  task automatic queue_directed();
    msg_item_t idle_it;
    @(negedge clk_i);
    queue_message(0, 1'b1, PatRandom);   // empty message returns the seed
    queue_message(1, 1'b0, PatZeros);    // one zero byte, seven pad bytes
    queue_message(1, 1'b0, PatOnes);     // one 0xff byte
    queue_message(8, 1'b0, PatOnes);     // exact block: no pad block
    queue_message(0, 1'b1, PatRandom);   // empty right after a full block
    idle_it = '{data: 8'hA5, present: 1'b0, last: 1'b0};
    pending_items = {pending_items, idle_it};  // idle item between messages
    queue_message(7, 1'b1, PatOnes);     // partial block closed by an end marker
    queue_message(3, 1'b0, PatRandom);
  endtask

  // Random messages until about target non-idle items are queued.
  task automatic queue_random(input int unsigned target);
    int unsigned count;
    int unsigned nbytes;
    int unsigned pick;
    bit          empty_end;
    count = 0;
    @(negedge clk_i);
    while (count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        nbytes = 0;
      end else if (pick < 20) begin
        nbytes = BlockBytes * $urandom_range(1, 4);
      end else if (pick < 28) begin
        nbytes = $urandom_range(25, 64);
      end else begin
        nbytes = $urandom_range(1, 24);
      end
      empty_end = (nbytes == 0) || ($urandom_range(0, 99) < 30);
      queue_message(nbytes, empty_end, PatRandom);
      count += nbytes + (empty_end ? 1 : 0);
    end
  endtask

  // Wait until every item is in and every hash is out, then let the block settle.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (hash_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the seed register while the block is idle.
  task automatic write_seed(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    adler_chain_reseed(value);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= $urandom();
  endtask

  // Set the idle rates between edges so the driver and monitor see them cleanly.
  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk_i);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_gap_pct   = IdlePct;
    recv_stall_pct = IdlePct;
    seed_chain     = DefaultChain;
    run_chain      = DefaultChain;
    adler_open_block();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset seed first, then the extremes of the register.
    queue_directed();
    drain();

    write_seed(32'h0000_0000);
    queue_directed();
    queue_random(200);
    drain();

    write_seed(32'hFFFF_FFFF);
    queue_directed();
    queue_random(200);
    drain();

    // Hold the receiver off long enough to fill the output and stall the input.
    write_seed($urandom());
    @(negedge clk_i);
    hold_req = 1'b1;
    queue_random(350);
    drain();

    // A stretch with no idling on either side.
    write_seed($urandom());
    set_idling(0, 0);
    queue_random(250);
    drain();

    write_seed($urandom());
    set_idling(IdlePct, IdlePct);
    queue_random(300);
    drain();

    write_seed(32'h8000_0001);
    queue_random(250);
    drain();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/md_adl_pkg.sv
hw/rtl/md_adl_step.sv
hw/rtl/md_chained_adler32_hash.sv
dv/md_chained_adler32_hash_tb.sv
